>>> design/cbrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_pkg
// Shared types and constants of the cartridge bank register decoder.
// ----------------------------------------------------------------------------
package cbrd_pkg;

  localparam int unsigned BANK_W    = 8;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CHR_SLOTS = 8;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_VARIANT = 2'd0;
  localparam logic [1:0] REG_PRG_AND = 2'd1;
  localparam logic [1:0] REG_PRG_MAX = 2'd2;
  localparam logic [1:0] REG_CHR_MAX = 2'd3;

  // Top address nibbles of the register windows
  localparam logic [3:0] NIB_PRG0   = 4'h8;
  localparam logic [3:0] NIB_MIRROR = 4'h9;
  localparam logic [3:0] NIB_PRG1   = 4'hA;
  localparam logic [3:0] NIB_CHR_LO = 4'hB;
  localparam logic [3:0] NIB_CHR_HI = 4'hE;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PROG   = 2'd1,
    KIND_MIRROR = 2'd2,
    KIND_CHAR   = 2'd3
  } kind_e;

  typedef struct packed {
    logic              variant;
    logic [BANK_W-1:0] prg_and;
    logic [BANK_W-1:0] prg_max;
    logic [BANK_W-1:0] chr_max;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic              high_nib;
  } dec_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [BANK_W-1:0] wr_data;
  } mem_req_t;

endpackage

>>> design/cartridge_bank_register_decoder.sv
`timescale 1ns / 1ps
// Result path: a taken write transfer is registered in stage 1 and then in the
// output register, from which it is offered on the result channel.
// Throughput: one CPU write per cycle while the result channel does not stall,
// with the character bank memory forwarding the preceding write into its read.
// Reset: configuration returns to normal wiring and full masks, mirroring to
// vertical, and every character slot reads back as its own index.
// ----------------------------------------------------------------------------
// cartridge_bank_register_decoder
// Decodes CPU writes into program bank, mirroring and character bank
// registers and reports the register each write updated.
// ----------------------------------------------------------------------------
module cartridge_bank_register_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbrd_pkg::PADDR_W-1:0] paddr,
  input  logic [cbrd_pkg::PDATA_W-1:0] pwdata,
  output logic [cbrd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // CPU write channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [15:0]                  cpu_address_i,
  input  logic [7:0]                   cpu_data_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   target_kind_o,
  output logic [2:0]                   target_slot_o,
  output logic [7:0]                   bank_number_o,
  output logic                         mirror_horizontal_o
);

  cbrd_pkg::cfg_t     cfg;
  cbrd_pkg::dec_t     dec;
  cbrd_pkg::mem_req_t mem_req;

  // stage 1: decoded write waiting on the bank memory read
  logic                        s1_valid_q;
  cbrd_pkg::dec_t              s1_dec_q;
  logic [7:0]                  s1_data_q;

  // output register
  logic                        out_valid_q;
  cbrd_pkg::kind_e             out_kind_q;
  logic [cbrd_pkg::SLOT_W-1:0] out_slot_q;
  logic [cbrd_pkg::BANK_W-1:0] out_bank_q;
  logic                        out_mirror_q;

  logic                        mirror_q;
  logic                        mirror_d;

  logic                        out_load;
  logic                        s1_adv;
  logic                        in_xfer;
  logic [cbrd_pkg::BANK_W-1:0] chr_old;
  logic [3:0]                  nib;
  logic [cbrd_pkg::BANK_W-1:0] chr_raw;
  logic [cbrd_pkg::BANK_W-1:0] chr_new;
  logic [cbrd_pkg::BANK_W-1:0] prg_raw;
  logic [cbrd_pkg::BANK_W-1:0] prg_new;
  logic [cbrd_pkg::SLOT_W-1:0] res_slot;
  logic [cbrd_pkg::BANK_W-1:0] res_bank;

  cbrd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbrd_decode u_dec (
    .addr_i    (cpu_address_i),
    .variant_i (cfg.variant),
    .dec_o     (dec)
  );

  // Handshake: the output register frees when empty or taken; stage 1 moves
  // on whenever the output register can load, so a new transfer is taken in
  // the same cycle as the previous result is handed on.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Read the slot on every transfer in; write back when stage 1 moves on with a character write.
  // The memory forwards a same-edge write into the read.
  assign mem_req.rd_en   = in_xfer;
  assign mem_req.rd_slot = dec.slot;
  assign mem_req.wr_en   = s1_adv && (s1_dec_q.kind == cbrd_pkg::KIND_CHAR);
  assign mem_req.wr_slot = s1_dec_q.slot;
  assign mem_req.wr_data = chr_new;

  cbrd_bank_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .old_o  (chr_old)
  );

  // Character nibble merge. The variant board drops the low data bit: the
  // low nibble shifts right by one and the high nibble lands one bit lower,
  // its lowest bit ORed into bit 3 of the old value.
  assign nib = s1_data_q[3:0];

  always_comb begin
    if (!s1_dec_q.high_nib) begin
      chr_raw = cfg.variant ? {chr_old[7:4], 1'b0, nib[3:1]} : {chr_old[7:4], nib};
    end else begin
      chr_raw = cfg.variant ? {1'b0, nib[3:1], chr_old[3] | nib[0], chr_old[2:0]}
                            : {nib, chr_old[3:0]};
    end
  end

  // Limit: a bank above the maximum is folded back with it as a mask
  assign chr_new = (chr_raw > cfg.chr_max) ? (chr_raw & cfg.chr_max) : chr_raw;
  assign prg_raw = s1_data_q & cfg.prg_and;
  assign prg_new = (prg_raw > cfg.prg_max) ? (prg_raw & cfg.prg_max) : prg_raw;

  always_comb begin
    res_slot = '0;
    res_bank = '0;
    mirror_d = mirror_q;
    case (s1_dec_q.kind)
      cbrd_pkg::KIND_PROG: begin
        res_slot = s1_dec_q.slot;
        res_bank = prg_new;
      end
      cbrd_pkg::KIND_MIRROR: begin
        mirror_d = s1_data_q[0];
      end
      cbrd_pkg::KIND_CHAR: begin
        res_slot = s1_dec_q.slot;
        res_bank = chr_new;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mirror_q    <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        mirror_q <= mirror_d;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_dec_q  <= dec;
      s1_data_q <= cpu_data_i;
    end
    if (s1_adv) begin
      out_kind_q   <= s1_dec_q.kind;
      out_slot_q   <= res_slot;
      out_bank_q   <= res_bank;
      out_mirror_q <= mirror_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign target_kind_o       = out_kind_q;
  assign target_slot_o       = out_slot_q;
  assign bank_number_o       = out_bank_q;
  assign mirror_horizontal_o = out_mirror_q;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with no item held");

  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_kind_o == cbrd_pkg::KIND_NONE ||
                    target_kind_o == cbrd_pkg::KIND_MIRROR)
    |-> target_slot_o == '0 && bank_number_o == '0)
    else $error("non-bank result carries slot or bank");

  a_prog_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_kind_o == cbrd_pkg::KIND_PROG |-> target_slot_o[2:1] == 2'b00)
    else $error("program result outside slots 0 and 1");

  a_mirror_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_dec_q.kind == cbrd_pkg::KIND_MIRROR |=> mirror_q == $past(s1_data_q[0]))
    else $error("mirroring not updated by its write");
`endif

endmodule

>>> design/cbrd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_cfg_regs
// APB register file holding board wiring and bank limit settings.
// ----------------------------------------------------------------------------
module cbrd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbrd_pkg::PADDR_W-1:0] paddr,
  input  logic [cbrd_pkg::PDATA_W-1:0] pwdata,
  output logic [cbrd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output cbrd_pkg::cfg_t               cfg_o
);

  cbrd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.variant <= 1'b0;
      cfg_q.prg_and <= '1;
      cfg_q.prg_max <= '1;
      cfg_q.chr_max <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        cbrd_pkg::REG_VARIANT: cfg_q.variant <= pwdata[0];
        cbrd_pkg::REG_PRG_AND: cfg_q.prg_and <= pwdata[cbrd_pkg::BANK_W-1:0];
        cbrd_pkg::REG_PRG_MAX: cfg_q.prg_max <= pwdata[cbrd_pkg::BANK_W-1:0];
        cbrd_pkg::REG_CHR_MAX: cfg_q.chr_max <= pwdata[cbrd_pkg::BANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      cbrd_pkg::REG_VARIANT: prdata[0] = cfg_q.variant;
      cbrd_pkg::REG_PRG_AND: prdata[cbrd_pkg::BANK_W-1:0] = cfg_q.prg_and;
      cbrd_pkg::REG_PRG_MAX: prdata[cbrd_pkg::BANK_W-1:0] = cfg_q.prg_max;
      cbrd_pkg::REG_CHR_MAX: prdata[cbrd_pkg::BANK_W-1:0] = cfg_q.chr_max;
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/cbrd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_decode
// CPU write address decode into register kind, slot and nibble select.
// ----------------------------------------------------------------------------
module cbrd_decode (
  input  logic [cbrd_pkg::ADDR_W-1:0] addr_i,
  input  logic                        variant_i,
  output cbrd_pkg::dec_t              dec_o
);

  logic [3:0] top;
  logic [1:0] low;
  logic [3:0] chr_row;

  assign top     = addr_i[cbrd_pkg::ADDR_W-1:cbrd_pkg::ADDR_W-4];
  // variant wiring swaps A0 and A1
  assign low     = variant_i ? {addr_i[0], addr_i[1]} : addr_i[1:0];
  assign chr_row = top - cbrd_pkg::NIB_CHR_LO;

  always_comb begin
    dec_o.kind     = cbrd_pkg::KIND_NONE;
    dec_o.slot     = '0;
    dec_o.high_nib = 1'b0;
    if (top == cbrd_pkg::NIB_PRG0) begin
      dec_o.kind = cbrd_pkg::KIND_PROG;
    end else if (top == cbrd_pkg::NIB_PRG1) begin
      dec_o.kind = cbrd_pkg::KIND_PROG;
      dec_o.slot = 3'd1;
    end else if (top == cbrd_pkg::NIB_MIRROR) begin
      dec_o.kind = cbrd_pkg::KIND_MIRROR;
    end else if (top >= cbrd_pkg::NIB_CHR_LO && top <= cbrd_pkg::NIB_CHR_HI) begin
      dec_o.kind     = cbrd_pkg::KIND_CHAR;
      dec_o.slot     = {chr_row[1:0], low[1]};
      dec_o.high_nib = low[0];
    end
  end

endmodule

>>> design/cbrd_bank_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_bank_mem
// Character bank store: synchronous memory with per-entry valid bits and
// write-to-read forwarding for back-to-back access to the same slot.
// ----------------------------------------------------------------------------
module cbrd_bank_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cbrd_pkg::mem_req_t          req_i,
  output logic [cbrd_pkg::BANK_W-1:0] old_o
);

  logic [cbrd_pkg::BANK_W-1:0]    mem [cbrd_pkg::CHR_SLOTS];
  logic [cbrd_pkg::BANK_W-1:0]    rd_data_q;
  logic [cbrd_pkg::CHR_SLOTS-1:0] ent_vld_q;
  logic                           rd_vld_q;
  logic                           hit_q;
  logic [cbrd_pkg::BANK_W-1:0]    fwd_q;
  logic [cbrd_pkg::SLOT_W-1:0]    rd_slot_q;
  logic                           hit;

  assign hit = req_i.wr_en && (req_i.wr_slot == req_i.rd_slot);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_slot] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      fwd_q     <= req_i.wr_data;
      rd_slot_q <= req_i.rd_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        ent_vld_q[req_i.wr_slot] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= ent_vld_q[req_i.rd_slot];
        hit_q    <= hit;
      end
    end
  end

  // an entry never written reads as its own slot number
  assign old_o = hit_q    ? fwd_q :
                 rd_vld_q ? rd_data_q :
                 {{(cbrd_pkg::BANK_W-cbrd_pkg::SLOT_W){1'b0}}, rd_slot_q};

endmodule
